// File: rtl/core/cba_pkg.sv
// Shared constants and field layouts for the code block allocator.
package cba_pkg;

  // Field widths of requests and results.
  localparam int REQ_W   = 24;
  localparam int ADDR_W  = 21;
  localparam int SIZE_W  = 19;
  localparam int STAT_W  = 2;
  localparam int LIMIT_W = 4;

  // Stream bus widths: request tdata and result tdata, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // One free-list entry: address in the low bits, size above it.
  localparam int ENTRY_W = ADDR_W + SIZE_W;

  // Fit ratio bound 1.3, kept as 13/10 in integers.
  localparam logic [3:0] FIT_NUM = 4'd13;
  localparam logic [3:0] FIT_DEN = 4'd10;

  // Largest size a free-list entry can hold.
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  // Reset value of the range limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  // Request kinds carried in tuser.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd3;

endpackage

// File: rtl/core/cba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/code_block_allocator_unit.sv
// Code block allocator: first-fit free list over a RAM, bump allocation over ranges.
// Requests are taken only in IDLE; a free settles on acceptance and posts from FINISH.
// An allocate checks each free-list entry (F_RD, F_CHK), moves later entries up after
// a hit (SH_RD, SH_WR), divides (DIV, R_START), checks each open range (R_RD, R_CHK),
// opens a range (OPEN) and posts (FINISH); each memory has one registered read port.
// Reset (rst, synchronous) empties the free list and closes all ranges at once.
module code_block_allocator_unit #(
  parameter int CHUNK_BYTES      = 64,
  parameter int CHUNKS_PER_RANGE = 4096,
  parameter int FREE_SLOTS       = 32,
  parameter int MAX_RANGES       = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // Request stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata: req_size[23:0], address[44:24], null_pointer[45], zero pad[47:46]
  input  logic [cba_pkg::IN_DATA_W-1:0] s_tdata,
  // tuser: action[0]
  input  logic                          s_tuser,
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata: status[1:0], block_address[22:2], block_size[41:23], zero pad[47:42]
  output logic [cba_pkg::OUT_DATA_W-1:0] m_tdata,
  // Range limit register write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cba_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int AW  = cba_pkg::ADDR_W;
  localparam int SW  = cba_pkg::SIZE_W;
  localparam int RW  = cba_pkg::REQ_W;
  localparam int EW  = cba_pkg::ENTRY_W;
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int FIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int ROW = $clog2(MAX_RANGES + 1);
  localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW  = $clog2(CHUNKS_PER_RANGE + 1);
  localparam int RANGE_BYTES = CHUNKS_PER_RANGE * CHUNK_BYTES;

  // Chunk count by reciprocal multiplication: exact for every dividend below 2**XW.
  localparam int XW = RW + 1;
  localparam int DL = $clog2(CHUNK_BYTES);
  localparam int DK = XW + DL;
  localparam logic [63:0] DM = ((64'd1 << DK) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);
  localparam int MW = XW + 1;
  localparam int PW = XW + MW;
  localparam int QW = XW;
  localparam int SUMW = QW + 1;

  typedef enum logic [3:0] {
    IDLE, F_RD, F_CHK, SH_RD, SH_WR, DIV, R_START, R_RD, R_CHK, OPEN, FINISH
  } state_t;

  state_t state;

  // Latched request.
  logic [RW-1:0]  req;

  // Control state.
  logic [FCW-1:0] free_count;
  logic [FCW-1:0] idx;
  logic [FCW-1:0] j;
  logic [ROW-1:0] ranges_open;
  logic [ROW-1:0] r;
  logic [cba_pkg::LIMIT_W-1:0] range_limit;
  logic [PW-1:0]  prod;

  // Result under construction.
  logic [cba_pkg::STAT_W-1:0] res_status;
  logic [AW-1:0]  res_addr;
  logic [SW-1:0]  res_size;

  // Memory ports.
  logic           fl_we;
  logic [FIW-1:0] fl_waddr;
  logic [EW-1:0]  fl_wdata;
  logic [FIW-1:0] fl_raddr;
  logic [EW-1:0]  fl_rdata;
  logic           cu_we;
  logic [RIW-1:0] cu_waddr;
  logic [CW-1:0]  cu_wdata;
  logic [RIW-1:0] cu_raddr;
  logic [CW-1:0]  cu_rdata;

  // Request fields.
  logic           in_acc;
  logic [RW-1:0]  in_req;
  logic [AW-1:0]  in_addr;
  logic           in_null;
  logic           in_act;
  logic [SW-1:0]  in_size_sat;
  logic           free_ok;

  // Datapath terms.
  logic [AW-1:0]  ent_addr;
  logic [SW-1:0]  ent_size;
  logic           ent_match;
  logic [QW-1:0]  chunks;
  logic [SUMW-1:0] cur_sum;
  logic           cur_fit;
  logic           open_fit;
  logic           open_ok;
  logic [SW-1:0]  grant_size;
  logic           last_entry;
  logic           last_move;
  logic           last_range;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  assign in_acc  = s_tvalid && s_tready;
  assign in_req  = s_tdata[RW-1:0];
  assign in_addr = s_tdata[RW +: AW];
  assign in_null = s_tdata[RW + AW];
  assign in_act  = s_tuser;
  assign in_size_sat = (in_req > RW'(cba_pkg::SIZE_MAX)) ? cba_pkg::SIZE_MAX : in_req[SW-1:0];
  assign free_ok = !in_null && (in_req != '0) && (free_count < FCW'(FREE_SLOTS));

  // First-fit test on the entry just read: req <= s and 10*s <= 13*req.
  assign ent_addr  = fl_rdata[AW-1:0];
  assign ent_size  = fl_rdata[AW +: SW];
  assign ent_match = ((RW + 4)'(ent_size) >= (RW + 4)'(req)) &&
                     ((RW + 4)'(ent_size) * (RW + 4)'(cba_pkg::FIT_DEN) <=
                      (RW + 4)'(req) * (RW + 4)'(cba_pkg::FIT_NUM));

  assign last_entry = ((FCW + 1)'(idx) + (FCW + 1)'(1)) >= (FCW + 1)'(free_count);
  assign last_move  = ((FCW + 1)'(j) + (FCW + 1)'(2)) >= (FCW + 1)'(free_count);
  assign last_range = ((ROW + 1)'(r) + (ROW + 1)'(1)) >= (ROW + 1)'(ranges_open);

  // Bump allocation terms.
  assign chunks     = QW'(prod >> DK);
  assign cur_sum    = SUMW'(cu_rdata) + SUMW'(chunks);
  assign cur_fit    = cur_sum <= SUMW'(CHUNKS_PER_RANGE);
  assign open_fit   = chunks <= QW'(CHUNKS_PER_RANGE);
  assign open_ok    = (32'(ranges_open) < 32'(range_limit)) &&
                      (32'(ranges_open) < 32'(MAX_RANGES));
  assign grant_size = SW'(chunks) * SW'(CHUNK_BYTES);

  // Free-list memory port control.
  always_comb begin
    fl_we    = (state == SH_WR) || (in_acc && (in_act == cba_pkg::ACT_FREE) && free_ok);
    fl_waddr = (state == SH_WR) ? j[FIW-1:0] : free_count[FIW-1:0];
    fl_wdata = (state == SH_WR) ? fl_rdata : {in_size_sat, in_addr};
    fl_raddr = (state == SH_RD) ? FIW'(j + 1'b1) : idx[FIW-1:0];
  end

  // Chunk cursor memory port control.
  always_comb begin
    cu_we    = ((state == R_CHK) && cur_fit) || ((state == OPEN) && open_ok);
    cu_waddr = (state == R_CHK) ? r[RIW-1:0] : ranges_open[RIW-1:0];
    cu_wdata = (state == R_CHK) ? CW'(cur_sum) : (open_fit ? CW'(chunks) : '0);
    cu_raddr = r[RIW-1:0];
  end

  cba_ram #(.WIDTH(EW), .DEPTH(FREE_SLOTS)) u_free_list (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  cba_ram #(.WIDTH(CW), .DEPTH(MAX_RANGES)) u_cursor (
    .clk   (clk),
    .we    (cu_we),
    .waddr (cu_waddr),
    .wdata (cu_wdata),
    .raddr (cu_raddr),
    .rdata (cu_rdata)
  );

  // Range limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= cba_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      range_limit <= cfg_data;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      free_count  <= '0;
      ranges_open <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            req        <= in_req;
            res_addr   <= '0;
            res_size   <= '0;
            idx        <= '0;
            if (in_act == cba_pkg::ACT_FREE) begin
              // A free request settles in this cycle.
              if (in_null || in_req == '0) begin
                res_status <= cba_pkg::ST_IGNORED;
              end else if (!free_ok) begin
                res_status <= cba_pkg::ST_DROPPED;
              end else begin
                res_status <= cba_pkg::ST_OK;
                free_count <= free_count + 1'b1;
              end
              state <= FINISH;
            end else begin
              res_status <= cba_pkg::ST_OK;
              state      <= (free_count == '0) ? DIV : F_RD;
            end
          end
        end
        F_RD: begin
          state <= F_CHK;
        end
        F_CHK: begin
          if (ent_match) begin
            // Hit: grant the entry, then move the later entries up by one.
            res_addr <= ent_addr;
            res_size <= ent_size;
            j        <= idx;
            if (last_entry) begin
              free_count <= free_count - 1'b1;
              state      <= FINISH;
            end else begin
              state <= SH_RD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= last_entry ? DIV : F_RD;
          end
        end
        SH_RD: begin
          state <= SH_WR;
        end
        SH_WR: begin
          j <= j + 1'b1;
          if (last_move) begin
            free_count <= free_count - 1'b1;
            state      <= FINISH;
          end else begin
            state <= SH_RD;
          end
        end
        DIV: begin
          // Round the request up to whole chunks.
          prod  <= PW'(XW'(req) + XW'(CHUNK_BYTES - 1)) * PW'(DM[MW-1:0]);
          state <= R_START;
        end
        R_START: begin
          r     <= '0;
          state <= (ranges_open == '0) ? OPEN : R_RD;
        end
        R_RD: begin
          state <= R_CHK;
        end
        R_CHK: begin
          if (cur_fit) begin
            res_addr <= AW'(r) * AW'(RANGE_BYTES) + AW'(cu_rdata) * AW'(CHUNK_BYTES);
            res_size <= grant_size;
            state    <= FINISH;
          end else begin
            r     <= r + 1'b1;
            state <= last_range ? OPEN : R_RD;
          end
        end
        OPEN: begin
          // Open a new range and carve from its start; on a miss it stays open, cursor at zero.
          if (open_ok) begin
            ranges_open <= ranges_open + 1'b1;
            if (open_fit) begin
              res_addr <= AW'(ranges_open) * AW'(RANGE_BYTES);
              res_size <= grant_size;
            end else begin
              res_status <= cba_pkg::ST_NOSPACE;
            end
          end else begin
            res_status <= cba_pkg::ST_NOSPACE;
          end
          state <= FINISH;
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {(cba_pkg::OUT_DATA_W - SW - AW - cba_pkg::STAT_W)'(0),
                         res_size, res_addr, res_status};
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/code_block_allocator_unit_tb.sv
// Self-checking testbench for the code block allocator: stream stimulus, predicted grants.
`timescale 1ns / 1ps

module code_block_allocator_unit_tb;

  localparam int CHUNK_BYTES      = 64;
  localparam int CHUNKS_PER_RANGE = 4096;
  localparam int FREE_SLOTS       = 32;
  localparam int MAX_RANGES       = 8;
  // Watchdog bound: a wide margin over the slowest allocates for every request queued.
  localparam int CYCLE_LIMIT      = 1500000;
  localparam int SETTLE_CYCLES    = 200;

  typedef struct packed {
    logic                       action;
    logic [cba_pkg::REQ_W-1:0]  size;
    logic [cba_pkg::ADDR_W-1:0] addr;
    logic                       nullp;
  } request_t;

  typedef struct packed {
    logic [cba_pkg::STAT_W-1:0] status;
    logic [cba_pkg::ADDR_W-1:0] block_address;
    logic [cba_pkg::SIZE_W-1:0] block_size;
  } outcome_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [cba_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = cba_pkg::ACT_ALLOC;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [cba_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [cba_pkg::LIMIT_W-1:0]    cfg_data = '0;

  // Predicted allocator state.
  logic [cba_pkg::ADDR_W-1:0]  free_addr [FREE_SLOTS];
  logic [cba_pkg::SIZE_W-1:0]  free_size [FREE_SLOTS];
  int                          free_count = 0;
  int                          ranges_open = 0;
  int                          range_cursor [MAX_RANGES];
  logic [cba_pkg::LIMIT_W-1:0] range_limit = cba_pkg::LIMIT_RESET;

  request_t request_queue [$];
  outcome_t outcome_queue [$];
  request_t active_req;
  int       recent_sizes [$];
  bit       calm = 1'b0;
  int       errors = 0;

  code_block_allocator_unit #(
    .CHUNK_BYTES      (CHUNK_BYTES),
    .CHUNKS_PER_RANGE (CHUNKS_PER_RANGE),
    .FREE_SLOTS       (FREE_SLOTS),
    .MAX_RANGES       (MAX_RANGES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Takes whole chunks from one range if they fit behind its cursor.
  function automatic bit carve_chunks(input int rng, input longint chunks, inout outcome_t res);
    longint cur;
    longint addr;
    longint bytes;
    cur = range_cursor[rng];
    if (cur + chunks > CHUNKS_PER_RANGE) return 1'b0;
    addr = longint'(rng) * CHUNKS_PER_RANGE * CHUNK_BYTES + cur * CHUNK_BYTES;
    bytes = chunks * CHUNK_BYTES;
    res.block_address = addr[cba_pkg::ADDR_W-1:0];
    res.block_size = bytes[cba_pkg::SIZE_W-1:0];
    range_cursor[rng] = int'(cur + chunks);
    return 1'b1;
  endfunction

  // Computes the result of one request and updates the predicted state.
  function automatic outcome_t allocator_outcome(input request_t r);
    outcome_t res;
    int       i;
    int       j;
    int       rng;
    int       lim;
    longint   s;
    longint   req;
    longint   chunks;
    bit       done;
    res = '0;
    req = r.size;
    done = 1'b0;
    if (r.action == cba_pkg::ACT_FREE) begin
      if (r.nullp || r.size == '0) begin
        res.status = cba_pkg::ST_IGNORED;
      end else if (free_count >= FREE_SLOTS) begin
        res.status = cba_pkg::ST_DROPPED;
      end else begin
        free_addr[free_count] = r.addr;
        free_size[free_count] = (req > cba_pkg::SIZE_MAX) ? cba_pkg::SIZE_MAX :
                                r.size[cba_pkg::SIZE_W-1:0];
        free_count++;
      end
      return res;
    end
    // First fit over the free list, oldest entry first.
    for (i = 0; i < free_count && !done; i++) begin
      s = free_size[i];
      if (s >= req && longint'(cba_pkg::FIT_DEN) * s <= longint'(cba_pkg::FIT_NUM) * req) begin
        res.block_address = free_addr[i];
        res.block_size = free_size[i];
        for (j = i; j + 1 < free_count; j++) begin
          free_addr[j] = free_addr[j + 1];
          free_size[j] = free_size[j + 1];
        end
        free_count--;
        done = 1'b1;
      end
    end
    // Bump allocation from open ranges, then from a newly opened one.
    if (!done) begin
      chunks = (req + CHUNK_BYTES - 1) / CHUNK_BYTES;
      for (rng = 0; rng < ranges_open && !done; rng++) begin
        done = carve_chunks(rng, chunks, res);
      end
      if (!done) begin
        lim = (range_limit > MAX_RANGES) ? MAX_RANGES : int'(range_limit);
        if (ranges_open < lim) begin
          range_cursor[ranges_open] = 0;
          ranges_open++;
          done = carve_chunks(ranges_open - 1, chunks, res);
        end
      end
      if (!done) begin
        res.status = cba_pkg::ST_NOSPACE;
        res.block_address = '0;
        res.block_size = '0;
      end
    end
    return res;
  endfunction

  task automatic push_req(input logic act, input logic [cba_pkg::REQ_W-1:0] sz,
                          input logic [cba_pkg::ADDR_W-1:0] ad, input logic np);
    request_t r;
    r.action = act;
    r.size = sz;
    r.addr = ad;
    r.nullp = np;
    request_queue = {request_queue, r};
  endtask

  // Random requests; allocations often aim at sizes freed earlier to exercise the fit window.
  task automatic queue_random(input int n, input int free_pct);
    int     k;
    int     sel;
    longint s;
    longint req;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if ($urandom_range(99) < free_pct) begin
        if (sel < 3) req = 0;
        else if (sel < 80) req = $urandom_range(1500, 1);
        else if (sel < 95) req = $urandom_range(40000, 1);
        else req = $urandom_range(24'hFFFFFF, 1);
        if (req != 0) begin
          recent_sizes = {recent_sizes,
                          (req > cba_pkg::SIZE_MAX) ? int'(cba_pkg::SIZE_MAX) : int'(req)};
          if (recent_sizes.size() > 16) void'(recent_sizes.pop_front());
        end
        push_req(cba_pkg::ACT_FREE, cba_pkg::REQ_W'(req), cba_pkg::ADDR_W'($urandom),
                 $urandom_range(99) < 5);
      end else begin
        if (sel < 45 && recent_sizes.size() != 0) begin
          s = recent_sizes[$urandom_range(recent_sizes.size() - 1)];
          case ($urandom_range(3))
            0: req = s;
            // Smallest request that the block still fits, and one below it.
            1: req = (10 * s + 12) / 13;
            2: req = (10 * s + 12) / 13 - 1;
            default: req = s * $urandom_range(120, 70) / 100;
          endcase
        end else if (sel < 75) begin
          req = $urandom_range(1024);
        end else if (sel < 92) begin
          req = $urandom_range(32768);
        end else begin
          req = $urandom_range(24'hFFFFFF);
        end
        push_req(cba_pkg::ACT_ALLOC, cba_pkg::REQ_W'(req), cba_pkg::ADDR_W'($urandom),
                 1'($urandom_range(1)));
      end
    end
  endtask

  // Returns at a falling edge once nothing is queued, presented or outstanding.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || s_tvalid || outcome_queue.size() != 0);
  endtask

  task automatic write_limit(input logic [cba_pkg::LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    range_limit = value;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Request driver: presents queued requests and predicts each one on acceptance.
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) outcome_queue = {outcome_queue, allocator_outcome(active_req)};
      if (!s_tvalid || s_tready) begin
        if (request_queue.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
          active_req = request_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, active_req.nullp, active_req.addr, active_req.size};
          s_tuser <= active_req.action;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : watch_results
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = outcome_queue.pop_front();
        check_field("status", want.status, m_tdata[1:0]);
        check_field("block_address", want.block_address, m_tdata[22:2]);
        check_field("block_size", want.block_size, m_tdata[41:23]);
      end
    end
    m_tready <= calm || ($urandom_range(99) >= 7);
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** code_block_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at the reset limit.
    push_req(cba_pkg::ACT_ALLOC, 0, 0, 1'b0);                  // zero size opens the first range
    push_req(cba_pkg::ACT_ALLOC, 1, 21'h1FFFFF, 1'b1);         // address and null ignored
    push_req(cba_pkg::ACT_ALLOC, 24'hFFFFFF, 0, 1'b0);         // opens a range, still no space
    push_req(cba_pkg::ACT_ALLOC, 262144, 0, 1'b0);             // exactly one full range
    push_req(cba_pkg::ACT_FREE, 100, 21'h1FFFFF, 1'b1);        // null pointer is ignored
    push_req(cba_pkg::ACT_FREE, 0, 5, 1'b0);                   // zero size is ignored
    push_req(cba_pkg::ACT_FREE, 24'hFFFFFF, 21'h1FFFFF, 1'b0); // stored saturated
    push_req(cba_pkg::ACT_FREE, 130, 21'h01234, 1'b0);
    push_req(cba_pkg::ACT_FREE, 131, 21'h02345, 1'b0);
    push_req(cba_pkg::ACT_FREE, 99, 21'h03456, 1'b0);
    push_req(cba_pkg::ACT_ALLOC, 100, 0, 1'b0);                // hits 130 right at the bound
    push_req(cba_pkg::ACT_ALLOC, 100, 0, 1'b0);                // 131 too large, 99 too small
    push_req(cba_pkg::ACT_ALLOC, 101, 0, 1'b0);                // takes 131
    push_req(cba_pkg::ACT_ALLOC, 99, 0, 1'b0);                 // exact fit
    push_req(cba_pkg::ACT_ALLOC, 524287, 0, 1'b0);             // takes the saturated block
    push_req(cba_pkg::ACT_FREE, 64, 0, 1'b0);
    push_req(cba_pkg::ACT_FREE, 65, 64, 1'b0);
    push_req(cba_pkg::ACT_ALLOC, 64, 0, 1'b0);
    push_req(cba_pkg::ACT_ALLOC, 50, 0, 1'b0);
    wait_idle();

    // Limit below the ranges already open: nothing new opens.
    write_limit(4'd1);
    queue_random(250, 45);
    wait_idle();
    write_limit(4'd0);
    queue_random(45, 100);
    queue_random(150, 45);
    wait_idle();
    write_limit(4'd3);
    queue_random(300, 45);
    wait_idle();

    // Limit above the range count, with no idling on either side.
    write_limit(4'd15);
    calm = 1'b1;
    queue_random(450, 45);
    wait_idle();
    calm = 1'b0;

    // Sender holds off mid-phase until every result is back.
    write_limit(4'd8);
    queue_random(300, 45);
    wait_idle();
    queue_random(300, 45);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** code_block_allocator_unit: PASSED **");
    end else begin
      $display("** code_block_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/cba_pkg.sv
rtl/core/cba_ram.sv
rtl/core/code_block_allocator_unit.sv
dv/code_block_allocator_unit_tb.sv
